### hw/rtl/carv_pkg.sv
package carv_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int CHANNELS_DEF    = 2;
    localparam int NUM_COMBS       = 4;
    localparam int NUM_ALLPASS     = 2;
    localparam int NUM_LINES       = NUM_COMBS + NUM_ALLPASS;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WORD_BITS       = 24;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 17;
    localparam int RATE_BITS       = 17;
    localparam int ACT_BITS        = 2;
    localparam int LINE_BITS       = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CH   = 1'd1;

    localparam logic [16:0] RATE_RESET   = 17'd44100;
    localparam logic [1:0]  ACTIVE_RESET = 2'd2;
    localparam logic [15:0] BASE_RATE    = 16'd44100;

    // floor(n / 44100) = floor((n >> 2) * LEN_RECIP >> LEN_SHIFT) for n < 2^28
    localparam logic [26:0] LEN_RECIP = 27'd99728946;
    localparam int          LEN_SHIFT = 40;

    localparam logic signed [15:0] C_FEEDBACK       = 16'sd27525;
    localparam logic signed [15:0] C_ONE_MINUS_DAMP = 16'sd26214;
    localparam logic signed [15:0] C_DAMP           = 16'sd6554;
    localparam logic signed [15:0] C_ALLPASS        = 16'sd16384;
    localparam logic signed [15:0] C_DRY            = 16'sd24576;
    localparam logic signed [15:0] C_WET            = 16'sd8192;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = 24'sh7FFFFF;
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = -24'sh800000;

    // tuning per line, right channel adds the stereo spread
    function automatic logic [11:0] line_tuning(input logic [LINE_BITS-1:0] line,
                                                input logic ch);
        logic [11:0] t;
        case (line)
            3'd0:    t = 12'd1557;
            3'd1:    t = 12'd1617;
            3'd2:    t = 12'd1491;
            3'd3:    t = 12'd1422;
            3'd4:    t = 12'd556;
            3'd5:    t = 12'd441;
            default: t = 12'd1;
        endcase
        return ch ? t + 12'd23 : t;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [47:0] v);
        if (v > 48'(WORD_MAX))
            return WORD_MAX;
        else if (v < 48'(WORD_MIN))
            return WORD_MIN;
        else
            return v[WORD_BITS-1:0];
    endfunction

endpackage

### hw/rtl/carv_stream_if.sv
interface carv_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/carv_ram.sv
module carv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/carv_mac.sv
// shared multiply unit: round(a*c / 2^15) ties up, registered
module carv_mac
    import carv_pkg::*;
(
    input  logic                        clk,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [15:0]          c,
    output logic signed [WORD_BITS+1:0] p_reg
);
    logic signed [WORD_BITS+16:0] prod;

    always_comb
    begin
        prod = (WORD_BITS+17)'(a) * (WORD_BITS+17)'(c) + (WORD_BITS+17)'(16384);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= prod[WORD_BITS+16:15];
    end
endmodule

### hw/rtl/comb_allpass_reverb_unit.sv
// Freeverb-style reverb, one sample in, one sample out. Each reverberated
// sample is worked by one shared multiplier under a sequencer through the
// four comb lines, then the two allpass lines, then the mix, and the next
// sample is taken only after the result transfer. Samples on an inactive
// channel are passed through unchanged. After reset and after any register
// write the block clears the delay RAM, one entry a cycle, 16*DELAY_DEPTH
// entries, and then computes the 12 line lengths by reciprocal
// multiplication; no sample is accepted meanwhile.
module comb_allpass_reverb_unit
    import carv_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    carv_stream_if.sink              in_chan,
    carv_stream_if.source            out_chan,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int LW = $clog2(DELAY_DEPTH + 1);
    localparam int NL = 2 * NUM_LINES;
    localparam int RA = AW + 4;

    typedef enum logic [13:0] {
        S_CLEAR = 14'd1,    S_LEN   = 14'd2,    S_IDLE  = 14'd4,
        S_RD    = 14'd8,    S_M1    = 14'd16,   S_M2    = 14'd32,
        S_M3    = 14'd64,   S_WR    = 14'd128,  S_AM1   = 14'd256,
        S_AM2   = 14'd512,  S_AWR   = 14'd1024, S_MIX1  = 14'd2048,
        S_MIX2  = 14'd4096, S_OUT   = 14'd8192
    } state_t;

    state_t state_reg, state_next;
    logic [RATE_BITS-1:0] rate_reg;
    logic [ACT_BITS-1:0]  act_reg;
    logic [AW:0]          clr_reg;
    logic [3:0]           lidx_reg;
    logic [1:0]           dstep_reg;
    logic [27:0]          num_reg;
    logic [12:0]          quo_reg;
    logic [LW-1:0]        len_reg [NL];
    logic [AW-1:0]        pos_reg [NL];
    logic signed [WORD_BITS-1:0] damp_reg [2*NUM_COMBS];
    logic [2:0]           line_reg;
    logic                 ch_reg;
    logic [1:0]           ph_reg;
    logic signed [WORD_BITS-1:0] dry_reg, y_reg, wet_reg, acc_reg;
    logic signed [WORD_BITS+3:0] sum_reg;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic                 ovalid_reg;

    // shared multiplier
    logic signed [WORD_BITS-1:0] mac_a;
    logic signed [15:0]          mac_c;
    logic signed [WORD_BITS+1:0] mac_p;
    carv_mac u_mac (.clk(clk), .a(mac_a), .c(mac_c), .p_reg(mac_p));

    // one RAM: all lines, address {line index, position}
    logic          ram_we;
    logic [RA-1:0] ram_wa, ram_ra;
    logic [WORD_BITS-1:0] ram_wd, ram_rd;
    carv_ram #(.WIDTH(WORD_BITS), .DEPTH(16 * (1 << AW))) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    logic [1:0] eff;
    logic       pass;
    logic signed [WORD_BITS-1:0] in_word;
    logic signed [WORD_BITS+1:0] mix_sum;
    logic [AW:0]   pos_inc;

    // line table is packed as ch*6+line
    function automatic logic [3:0] lt(input logic c, input logic [2:0] l);
        return c ? 4'(4'd6 + 4'(l)) : 4'(l);
    endfunction

    always_comb
    begin
        eff = (act_reg == 2'd0) ? 2'd1 :
              ((32'(act_reg) > CHANNELS) ? 2'(CHANNELS) : act_reg);
        pass = (32'(in_chan.data[SAMPLE_BITS]) >= 32'(eff)) ||
               (32'(in_chan.data[SAMPLE_BITS]) >= CHANNELS);
        in_word = WORD_BITS'($signed(in_chan.data[SAMPLE_BITS-1:0]));
        pos_inc = {1'b0, pos_reg[lt(ch_reg, line_reg)]} + 1'b1;
        mix_sum = (WORD_BITS+2)'(acc_reg) + mac_p;
    end

    assign in_chan.ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_chan.valid = ovalid_reg;
    assign out_chan.data  = out_reg;

    always_comb
    begin
        ram_ra = {lt(ch_reg, line_reg), pos_reg[lt(ch_reg, line_reg)]};
        ram_we = 1'b0;
        ram_wa = ram_ra;
        ram_wd = '0;
        mac_a  = '0;
        mac_c  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_wa = {lidx_reg, clr_reg[AW-1:0]};
            end
            S_M1:
            begin
                mac_a = WORD_BITS'(ram_rd);
                mac_c = C_ONE_MINUS_DAMP;
            end
            S_M2:
            begin
                mac_a = damp_reg[{ch_reg, line_reg[1:0]}];
                mac_c = C_DAMP;
            end
            S_M3:
            begin
                mac_a = acc_reg;
                mac_c = C_FEEDBACK;
            end
            S_WR:
            begin
                ram_we = 1'b1;
                ram_wd = sat_word(48'(dry_reg) + 48'(mac_p));
            end
            S_AM1:
            begin
                mac_a = wet_reg;
                mac_c = C_ALLPASS;
            end
            S_AM2:
            begin
                mac_a = WORD_BITS'(ram_rd);
                mac_c = C_ALLPASS;
            end
            S_AWR:
            begin
                ram_we = 1'b1;
                ram_wd = sat_word(48'(wet_reg) + 48'(mac_p));
            end
            S_MIX1:
            begin
                mac_a = dry_reg;
                mac_c = C_DRY;
            end
            S_MIX2:
            begin
                mac_a = wet_reg;
                mac_c = C_WET;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(DELAY_DEPTH - 1) && lidx_reg == 4'd15)
                state_next = S_LEN;
            S_LEN:   if (lidx_reg == 4'(NL - 1) && dstep_reg == 2'd2)
                state_next = S_IDLE;
            S_IDLE:  if (in_chan.valid && in_chan.ready && !pass)
                state_next = S_RD;
            S_RD:    state_next = (line_reg < 3'(NUM_COMBS)) ? S_M1 : S_AM1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = (ph_reg == 2'd2) ? S_WR : S_M3;
            S_WR:    state_next = S_RD;
            S_AM1:   state_next = S_AM2;
            S_AM2:   state_next = (ph_reg == 2'd1) ? S_AWR : S_AM2;
            S_AWR:   state_next = (line_reg == 3'(NUM_LINES - 1)) ? S_MIX1 : S_RD;
            S_MIX1:  state_next = S_MIX2;
            S_MIX2:  state_next = (ph_reg == 2'd1) ? S_OUT : S_MIX2;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
            state_next = S_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            rate_reg   <= RATE_RESET;
            act_reg    <= ACTIVE_RESET;
            clr_reg    <= '0;
            lidx_reg   <= '0;
            dstep_reg  <= '0;
            num_reg    <= '0;
            quo_reg    <= '0;
            ovalid_reg <= 1'b0;
            line_reg   <= '0;
            ph_reg     <= '0;
            ch_reg     <= 1'b0;
            dry_reg    <= '0;
            y_reg      <= '0;
            wet_reg    <= '0;
            acc_reg    <= '0;
            sum_reg    <= '0;
            out_reg    <= '0;
            for (int i = 0; i < NL; i++)
            begin
                pos_reg[i] <= '0;
                len_reg[i] <= LW'(1);
            end
            for (int i = 0; i < 2 * NUM_COMBS; i++)
                damp_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_chan.valid && out_chan.ready)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_SAMPLE_RATE)
                    rate_reg <= cfg_data[RATE_BITS-1:0];
                if (cfg_index == REG_ACTIVE_CH)
                    act_reg <= cfg_data[ACT_BITS-1:0];
                clr_reg  <= '0;
                lidx_reg <= '0;
                for (int i = 0; i < NL; i++)
                    pos_reg[i] <= '0;
                for (int i = 0; i < 2 * NUM_COMBS; i++)
                    damp_reg[i] <= '0;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        if (state_next == S_LEN)
                        begin
                            lidx_reg  <= '0;
                            dstep_reg <= '0;
                            num_reg   <= 28'(line_tuning(3'd0, 1'b0)) * 28'(rate_reg)
                                         + 28'(BASE_RATE / 2);
                        end
                        else
                        begin
                            lidx_reg <= lidx_reg + 1'b1;
                            if (lidx_reg == 4'd15)
                                clr_reg <= clr_reg + 1'b1;
                        end
                    end
                    S_LEN:
                    begin
                        if (dstep_reg == 2'd0)
                        begin
                            quo_reg <= 13'((53'(num_reg[27:2]) * 53'(LEN_RECIP))
                                           >> LEN_SHIFT);
                            dstep_reg <= 2'd1;
                        end
                        else if (dstep_reg == 2'd1)
                        begin
                            len_reg[lidx_reg] <= (quo_reg == 13'd0) ? LW'(1) :
                                (32'(quo_reg) > DELAY_DEPTH) ? LW'(DELAY_DEPTH) :
                                LW'(quo_reg);
                            dstep_reg <= 2'd2;
                        end
                        else
                        begin
                            lidx_reg  <= lidx_reg + 1'b1;
                            dstep_reg <= '0;
                            num_reg   <= 28'(line_tuning(
                                (lidx_reg + 1'b1 >= 4'd6) ? 3'(lidx_reg + 1'b1 - 4'd6)
                                                         : 3'(lidx_reg + 1'b1),
                                (lidx_reg + 1'b1 >= 4'd6))) * 28'(rate_reg)
                                + 28'(BASE_RATE / 2);
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_chan.valid && in_chan.ready)
                        begin
                            if (pass)
                            begin
                                out_reg    <= in_chan.data[SAMPLE_BITS-1:0];
                                ovalid_reg <= 1'b1;
                            end
                            ch_reg   <= in_chan.data[SAMPLE_BITS];
                            dry_reg  <= in_word;
                            line_reg <= '0;
                            sum_reg  <= '0;
                            ph_reg   <= '0;
                        end
                    end
                    S_RD: ph_reg <= '0;
                    S_M1: y_reg <= WORD_BITS'(ram_rd);
                    S_M2: acc_reg <= WORD_BITS'(mac_p);
                    S_M3:
                    begin
                        ph_reg <= ph_reg + 1'b1;
                        if (ph_reg == 2'd0)
                        begin
                            acc_reg <= sat_word(48'(acc_reg) + 48'(mac_p));
                            damp_reg[{ch_reg, line_reg[1:0]}] <=
                                sat_word(48'(acc_reg) + 48'(mac_p));
                        end
                    end
                    S_WR:
                    begin
                        sum_reg <= sum_reg + (WORD_BITS+4)'(y_reg);
                        pos_reg[lt(ch_reg, line_reg)] <=
                            (pos_inc >= (AW+1)'(len_reg[lt(ch_reg, line_reg)]) ||
                             pos_inc >= (AW+1)'(DELAY_DEPTH)) ? '0 : pos_inc[AW-1:0];
                        line_reg <= line_reg + 1'b1;
                        if (line_reg == 3'(NUM_COMBS - 1))
                            wet_reg <= sat_word(48'((sum_reg + (WORD_BITS+4)'(y_reg)
                                                     + 2) >>> 2));
                    end
                    S_AM1: y_reg <= WORD_BITS'(ram_rd);
                    S_AM2:
                    begin
                        ph_reg <= ph_reg + 1'b1;
                        if (ph_reg == 2'd0)
                            acc_reg <= sat_word(48'(y_reg) - 48'(mac_p));
                    end
                    S_AWR:
                    begin
                        wet_reg  <= acc_reg;
                        pos_reg[lt(ch_reg, line_reg)] <=
                            (pos_inc >= (AW+1)'(len_reg[lt(ch_reg, line_reg)]) ||
                             pos_inc >= (AW+1)'(DELAY_DEPTH)) ? '0 : pos_inc[AW-1:0];
                        line_reg <= line_reg + 1'b1;
                        ph_reg   <= '0;
                    end
                    S_MIX1: ph_reg <= '0;
                    S_MIX2:
                    begin
                        ph_reg <= ph_reg + 1'b1;
                        if (ph_reg == 2'd0)
                            acc_reg <= WORD_BITS'(mac_p);
                    end
                    S_OUT:
                    begin
                        ovalid_reg <= 1'b1;
                        if (mix_sum > (WORD_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1))
                            out_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                        else if (mix_sum < -(WORD_BITS+2)'(1 << (SAMPLE_BITS-1)))
                            out_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                        else
                            out_reg <= mix_sum[SAMPLE_BITS-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && !out_chan.ready |=> out_chan.valid)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid |-> !in_chan.ready) else $error("accept while result pending");
`endif
endmodule
